// ===== sv/note_timing_quantizer_assert.svh =====
// Assertion macros for the note timing quantizer.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef NOTE_TIMING_QUANTIZER_ASSERT_SVH
`define NOTE_TIMING_QUANTIZER_ASSERT_SVH

// Same-cycle property, sampled on clk_i, off during reset.
`define NTQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define NTQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ntq_pkg.sv =====
// Shared constants, types and helper functions for the note timing quantizer.
// No dependencies; compiled before every other file of the block.
package ntq_pkg;

  localparam int TICK_BITS_DEF = 32;
  localparam int PPQ_W         = 16;
  localparam int NOTE_W        = 3;
  localparam int MOD_W         = 2;
  localparam int Q8_W          = 9;
  localparam int Q8_FRAC       = 8;
  // widest step: dotted whole note, ppq*4*3/2
  localparam int GRID_W        = PPQ_W + 3;
  localparam int CFG_W         = PPQ_W;
  localparam int CFG_IDX_W     = 3;

  localparam logic [Q8_W-1:0] Q8_ONE  = 9'd256;
  localparam logic [Q8_W-1:0] Q8_HALF = 9'd128;

  // floor(y/3) = (y * ceil(2^21/3)) >> 21, exact for y < 2^21
  localparam int                     RECIP_SHIFT = 21;
  localparam logic [RECIP_SHIFT-1:0] RECIP3      = 21'd699051;

  // round(swing*grid/768) half up: (swing*grid + 384) / 768
  localparam logic [GRID_W+Q8_W-1:0] SWING_BIAS = 28'd384;

  typedef enum logic [MOD_W-1:0] {
    GRID_STRAIGHT = 2'd0,
    GRID_TRIPLET  = 2'd1,
    GRID_DOTTED   = 2'd2
  } grid_mod_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PPQ        = 3'd0,
    REG_NOTE       = 3'd1,
    REG_MOD        = 3'd2,
    REG_SWING      = 3'd3,
    REG_STRENGTH   = 3'd4,
    REG_SNAP_START = 3'd5,
    REG_SNAP_END   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PPQ_W-1:0]  ppq;
    logic [NOTE_W-1:0] note;
    logic [MOD_W-1:0]  gmod;
    logic [Q8_W-1:0]   swing;
    logic [Q8_W-1:0]   strength;
    logic              snap_start;
    logic              snap_end;
  } ntq_regs_t;

  localparam ntq_regs_t REGS_RST = '{
    ppq:        16'd480,
    note:       3'd4,
    gmod:       GRID_STRAIGHT,
    swing:      9'd0,
    strength:   9'd256,
    snap_start: 1'b1,
    snap_end:   1'b0
  };

  // Settings as the lanes and the merge stage see them.
  typedef struct packed {
    logic [GRID_W-1:0] grid;
    logic [GRID_W-1:0] swing_off;
    logic              swing_en;
    logic [Q8_W-1:0]   strength;
    logic              snap_start;
    logic              snap_end;
  } ntq_cfg_t;

  // Width of the dividend 2*tick + grid, also used for the snapped target.
  function automatic int div_bits(int tick_bits);
    return ((tick_bits > GRID_W) ? tick_bits : GRID_W) + 2;
  endfunction

  // Straight grid step from ppq and note value, never below one.
  function automatic logic [GRID_W-2:0] base_step(logic [PPQ_W-1:0] ppq,
                                                  logic [NOTE_W-1:0] nv);
    logic [GRID_W-2:0] p;
    logic [GRID_W-2:0] s;
    p = {2'b00, ppq};
    if (nv <= 3'd2) begin
      s = p << (3'd2 - nv);
    end else begin
      s = p >> (nv - 3'd2);
    end
    return (s == '0) ? (GRID_W-1)'(1) : s;
  endfunction

  function automatic logic [GRID_W-1:0] div3(logic [GRID_W:0] y);
    logic [GRID_W+RECIP_SHIFT:0] prod;
    prod = {{RECIP_SHIFT{1'b0}}, y} * {{(GRID_W+1){1'b0}}, RECIP3};
    return prod[RECIP_SHIFT +: GRID_W];
  endfunction

  function automatic logic [Q8_W-1:0] sat_q8(logic [Q8_W-1:0] v);
    return (v > Q8_ONE) ? Q8_ONE : v;
  endfunction

endpackage

// ===== sv/ntq_if.sv =====
// Valid/ready channel interfaces: note items in, quantized note items out.
// Depends on ntq_pkg for the default tick width.
interface ntq_note_if import ntq_pkg::*; #(parameter int TICK_BITS = TICK_BITS_DEF) ();
  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] start_tick;
  logic [TICK_BITS-1:0] end_tick;

  modport source (output valid, output start_tick, output end_tick, input ready);
  modport sink   (input valid, input start_tick, input end_tick, output ready);
endinterface

interface ntq_result_if import ntq_pkg::*; #(parameter int TICK_BITS = TICK_BITS_DEF) ();
  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] new_start;
  logic [TICK_BITS-1:0] new_end;

  modport source (output valid, output new_start, output new_end, input ready);
  modport sink   (input valid, input new_start, input new_end, output ready);
endinterface

// ===== sv/ntq_grid.sv =====
// Derives grid step, swing offset and saturated strength from the settings.
// Depends on ntq_pkg; the swing offset is the last output to settle after a write.
module ntq_grid import ntq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ntq_regs_t regs_i,
  output ntq_cfg_t  cfg_o
);

  localparam logic [GRID_W-2:0] BASE_RST = base_step(REGS_RST.ppq, REGS_RST.note);

  logic [GRID_W-2:0]      base_d, base_q;
  logic [Q8_W-1:0]        sw_q, st_q;
  logic                   snap_start_q, snap_end_q;
  logic [GRID_W:0]        dbl, trip;
  logic [GRID_W-1:0]      grid_sel;
  logic [GRID_W-1:0]      grid_d, grid_q;
  logic [GRID_W+Q8_W-1:0] swp_d, swp_q;
  logic [GRID_W-1:0]      off_d, off_q;

  assign base_d = base_step(regs_i.ppq, regs_i.note);

  always_comb begin
    dbl  = {1'b0, base_q, 1'b0};
    trip = {2'b00, base_q} + {1'b0, base_q, 1'b0};
    case (regs_i.gmod)
      GRID_TRIPLET: grid_sel = div3(dbl);
      GRID_DOTTED:  grid_sel = trip[GRID_W:1];
      default:      grid_sel = {1'b0, base_q};
    endcase
    grid_d = (grid_sel == '0) ? GRID_W'(1) : grid_sel;
  end

  assign swp_d = {{GRID_W{1'b0}}, sw_q} * {{Q8_W{1'b0}}, grid_q} + SWING_BIAS;
  assign off_d = div3(swp_q[GRID_W+Q8_W-1:Q8_FRAC]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= BASE_RST;
      sw_q         <= sat_q8(REGS_RST.swing);
      st_q         <= sat_q8(REGS_RST.strength);
      snap_start_q <= REGS_RST.snap_start;
      snap_end_q   <= REGS_RST.snap_end;
      grid_q       <= {1'b0, BASE_RST};
      swp_q        <= SWING_BIAS;
      off_q        <= '0;
    end else begin
      base_q       <= base_d;
      sw_q         <= sat_q8(regs_i.swing);
      st_q         <= sat_q8(regs_i.strength);
      snap_start_q <= regs_i.snap_start;
      snap_end_q   <= regs_i.snap_end;
      grid_q       <= grid_d;
      swp_q        <= swp_d;
      off_q        <= off_d;
    end
  end

  assign cfg_o.grid       = grid_q;
  assign cfg_o.swing_off  = off_q;
  assign cfg_o.swing_en   = (sw_q != '0);
  assign cfg_o.strength   = st_q;
  assign cfg_o.snap_start = snap_start_q;
  assign cfg_o.snap_end   = snap_end_q;

endmodule

// ===== sv/ntq_lane.sv =====
// One quantizer lane: pipelined restoring divide by twice the grid, swing, blend.
// Depends on ntq_pkg; data only, the valid bits live in the top level.
module ntq_lane import ntq_pkg::*; #(parameter int TICK_BITS = TICK_BITS_DEF) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  ntq_cfg_t             cfg_i,
  input  logic [TICK_BITS-1:0] tick_i,
  output logic [TICK_BITS-1:0] snap_o,
  output logic [TICK_BITS-1:0] tick_o
);

  localparam int NW   = div_bits(TICK_BITS);
  localparam int DW   = GRID_W + 1;
  localparam int PA_W = TICK_BITS + Q8_W;
  localparam int PB_W = NW + Q8_W;
  localparam int SM_W = PB_W + 1;

  logic [TICK_BITS-1:0] t0_q, t1_q;
  logic [NW-1:0]        num_q [NW+1];
  logic [DW-1:0]        rem_q [1:NW];
  logic [DW-1:0]        dvs;
  logic                 odd_q;

  logic [NW-2:0]        tgt_q;
  logic [TICK_BITS-1:0] tk1_q, tk2_q, tk3_q, tk4_q;
  logic                 odd1_q;
  logic [NW-1:0]        tsw_q;
  logic [Q8_W-1:0]      inv_st;
  logic [PA_W-1:0]      pa_q;
  logic [PB_W-1:0]      pb_q;
  logic [SM_W-1:0]      sum;
  logic [NW+1:0]        blend;
  logic [TICK_BITS-1:0] snap_q;

  // divisor 2*grid; dividend 2*tick + grid, so the quotient is the rounded index
  assign dvs = {cfg_i.grid, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q     <= tick_i;
      t1_q     <= t0_q;
      num_q[0] <= {{(NW-TICK_BITS-1){1'b0}}, t1_q, 1'b0} + NW'(cfg_i.grid);
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DW-1:0] r_in;
    logic [DW:0]   trial;
    logic          hit;

    if (k == 0) begin : g_first
      assign r_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k];
    end

    assign trial = {r_in, num_q[k][NW-1-k]};
    assign hit   = (trial >= {1'b0, dvs});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= num_q[k];
        rem_q[k+1] <= hit ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      end
    end

    if (k == NW - 1) begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          odd_q <= hit;
        end
      end
    end
  end

  assign inv_st = Q8_ONE - cfg_i.strength;
  assign sum    = {{(SM_W-PA_W){1'b0}}, pa_q} + {1'b0, pb_q} + SM_W'(Q8_HALF);
  assign blend  = sum[SM_W-1:Q8_FRAC];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // index*grid = (dividend - remainder)/2; tick = (dividend - grid)/2
      tgt_q  <= (NW-1)'((num_q[NW] - NW'(rem_q[NW])) >> 1);
      tk1_q  <= TICK_BITS'((num_q[NW] - NW'(cfg_i.grid)) >> 1);
      odd1_q <= odd_q;

      tsw_q  <= {1'b0, tgt_q} + ((cfg_i.swing_en && odd1_q) ? NW'(cfg_i.swing_off) : '0);
      tk2_q  <= tk1_q;

      pa_q   <= {{TICK_BITS{1'b0}}, inv_st} * {{Q8_W{1'b0}}, tk2_q};
      pb_q   <= {{NW{1'b0}}, cfg_i.strength} * {{Q8_W{1'b0}}, tsw_q};
      tk3_q  <= tk2_q;

      snap_q <= (|blend[NW+1:TICK_BITS]) ? '1 : blend[TICK_BITS-1:0];
      tk4_q  <= tk3_q;
    end
  end

  assign snap_o = snap_q;
  assign tick_o = tk4_q;

endmodule

// ===== sv/ntq_merge.sv =====
// Merge stage: picks start, keeps or snaps the end, forces end above start,
// and holds the output register. Depends on ntq_pkg and the assertion macros.
`include "note_timing_quantizer_assert.svh"

module ntq_merge import ntq_pkg::*; #(parameter int TICK_BITS = TICK_BITS_DEF) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ntq_cfg_t             cfg_i,
  input  logic [TICK_BITS-1:0] snap_s_i,
  input  logic [TICK_BITS-1:0] raw_s_i,
  input  logic [TICK_BITS-1:0] snap_e_i,
  input  logic [TICK_BITS-1:0] raw_e_i,
  input  logic                 m1_valid_i,
  output logic                 en_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TICK_BITS-1:0] new_start_o,
  output logic [TICK_BITS-1:0] new_end_o
);

  logic [TICK_BITS-1:0] ns_d, ns_q;
  logic [TICK_BITS+1:0] ne_d, ne_q;
  logic [TICK_BITS+1:0] ns_ext, ne_fix;
  logic [TICK_BITS-1:0] end_sat;
  logic                 out_vld_q;
  logic                 out_free;
  logic [TICK_BITS-1:0] start_q, end_q;

  assign ns_d = cfg_i.snap_start ? snap_s_i : raw_s_i;
  // unsnapped end keeps the (possibly negative) duration, two's complement
  assign ne_d = cfg_i.snap_end ? {2'b00, snap_e_i}
                               : {2'b00, ns_d} + {2'b00, raw_e_i} - {2'b00, raw_s_i};

  assign ns_ext  = {2'b00, ns_q};
  assign ne_fix  = ($signed(ne_q) <= $signed(ns_ext)) ? ns_ext + (TICK_BITS+2)'(1) : ne_q;
  assign end_sat = (|ne_fix[TICK_BITS+1:TICK_BITS]) ? '1 : ne_fix[TICK_BITS-1:0];

  assign out_free = !out_vld_q || out_ready_i;
  assign en_o     = !(m1_valid_i && !out_free);

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      ns_q <= ns_d;
      ne_q <= ne_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= m1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      start_q <= ns_q;
      end_q   <= end_sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign new_start_o = start_q;
  assign new_end_o   = end_q;

  `NTQ_ASSERT(a_end_above_start, out_vld_q |-> ((end_q > start_q) || ((start_q == '1) && (end_q == '1))), "result end not above start")
  `NTQ_ASSERT_NEXT(a_stall_keeps_result, !en_o, out_vld_q, "stalled pipeline lost its result")
  `NTQ_ASSERT_NEXT(a_item_reaches_output, m1_valid_i && en_o, out_vld_q, "item dropped at output")

endmodule

// ===== sv/note_timing_quantizer.sv =====
// Note timing quantizer: snaps note start/end ticks to a musical grid with
// swing and strength.
//
// Channels: note_i takes one item (start_tick, end_tick) per valid/ready
// handshake; result_o gives one item (new_start, new_end) for each, in order.
// Settings are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while no item is
// in flight; a note may be accepted from the cycle after a write.
// Throughput: one note per cycle while ready is high. Two lanes (start and
// end) each run a restoring divider by twice the grid step, one quotient bit
// per stage, then swing and strength blend; a merge stage combines the lanes.
// Path: each note passes the lane input registers, the divider stages (most of
// the path), the swing and blend registers, the merge and output registers.
// Stall: the pipeline only halts when the merge stage holds a finished note and
// the output register is full and not taken; ready then drops. Otherwise
// notes keep entering while a result waits.
// Reset: settings return to their defaults and the pipeline empties at once.
module note_timing_quantizer import ntq_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  ntq_note_if.sink             note_i,
  ntq_result_if.source         result_o
);

  localparam int LANE_LAT = div_bits(TICK_BITS) + 7;
  localparam int PIPE_LAT = LANE_LAT + 1;

  ntq_regs_t            regs_q;
  ntq_cfg_t             cfg;
  logic                 en;
  logic [PIPE_LAT-1:0]  vld_q;
  logic [TICK_BITS-1:0] snap_s, raw_s, snap_e, raw_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= REGS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PPQ:        regs_q.ppq        <= cfg_wdata_i;
        REG_NOTE:       regs_q.note       <= cfg_wdata_i[NOTE_W-1:0];
        REG_MOD:        regs_q.gmod       <= cfg_wdata_i[MOD_W-1:0];
        REG_SWING:      regs_q.swing      <= cfg_wdata_i[Q8_W-1:0];
        REG_STRENGTH:   regs_q.strength   <= cfg_wdata_i[Q8_W-1:0];
        REG_SNAP_START: regs_q.snap_start <= cfg_wdata_i[0];
        REG_SNAP_END:   regs_q.snap_end   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  ntq_grid u_grid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .regs_i (regs_q),
    .cfg_o  (cfg)
  );

  // one valid bit per pipeline step, last one is the merge stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], note_i.valid};
    end
  end

  assign note_i.ready = en;

  ntq_lane #(.TICK_BITS(TICK_BITS)) u_lane_start (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg),
    .tick_i (note_i.start_tick),
    .snap_o (snap_s),
    .tick_o (raw_s)
  );

  ntq_lane #(.TICK_BITS(TICK_BITS)) u_lane_end (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg),
    .tick_i (note_i.end_tick),
    .snap_o (snap_e),
    .tick_o (raw_e)
  );

  ntq_merge #(.TICK_BITS(TICK_BITS)) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .snap_s_i    (snap_s),
    .raw_s_i     (raw_s),
    .snap_e_i    (snap_e),
    .raw_e_i     (raw_e),
    .m1_valid_i  (vld_q[PIPE_LAT-1]),
    .en_o        (en),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .new_start_o (result_o.new_start),
    .new_end_o   (result_o.new_end)
  );

endmodule

// ===== sim/tb_note_timing_quantizer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for note_timing_quantizer: random valid/ready traffic on both channels.
// Depends on ntq_pkg, the ntq_note_if/ntq_result_if interfaces and the quantizer RTL.
module tb_note_timing_quantizer;
  import ntq_pkg::*;

  localparam int TICK_W = TICK_BITS_DEF;
  localparam longint unsigned TICK_LIMIT = (64'd1 << TICK_W) - 64'd1;
  localparam int RESULT_LATENCY = ((TICK_W > GRID_W) ? TICK_W : GRID_W) + 11;
  localparam int MAX_WAIT = 17;
  localparam int CHOKE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 40;

  typedef enum int unsigned {
    NOTE_WHOLE,
    NOTE_HALF,
    NOTE_QUARTER,
    NOTE_EIGHTH,
    NOTE_16TH,
    NOTE_32ND,
    NOTE_64TH,
    NOTE_128TH
  } note_len_e;

  // modifier code with no meaning of its own; the block treats it as straight
  localparam logic [MOD_W-1:0] GRID_RESERVED = 2'd3;

  typedef struct {
    logic [PPQ_W-1:0]  ppq;
    logic [NOTE_W-1:0] note_value;
    logic [MOD_W-1:0]  grid_mod;
    logic [Q8_W-1:0]   swing;
    logic [Q8_W-1:0]   strength;
    logic              snap_start;
    logic              snap_end;
  } grid_settings_t;

  typedef struct {
    logic [TICK_W-1:0] note_start;
    logic [TICK_W-1:0] note_end;
    logic [TICK_W-1:0] new_start;
    logic [TICK_W-1:0] new_end;
  } quantized_note_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  ntq_note_if   #(.TICK_BITS(TICK_W)) note_if ();
  ntq_result_if #(.TICK_BITS(TICK_W)) result_if ();

  grid_settings_t  settings;
  quantized_note_t quantized_q[$];
  quantized_note_t want;
  int unsigned     error_count = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     choke_left = 0;
  bit              gaps_on = 1'b1;
  bit              stalls_on = 1'b1;

  note_timing_quantizer #(.TICK_BITS(TICK_W)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .note_i      (note_if),
    .result_o    (result_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint unsigned grid_ticks();
    longint unsigned p;
    longint unsigned step;
    p = settings.ppq;
    case (settings.note_value)
      NOTE_WHOLE:   step = p << 2;
      NOTE_HALF:    step = p << 1;
      NOTE_QUARTER: step = p;
      NOTE_EIGHTH:  step = p >> 1;
      NOTE_16TH:    step = p >> 2;
      NOTE_32ND:    step = p >> 3;
      NOTE_64TH:    step = p >> 4;
      default:      step = p >> 5;
    endcase
    if (step == 0) step = 1;
    if (settings.grid_mod == GRID_TRIPLET) begin
      step = (step * 2) / 3;
    end else if (settings.grid_mod == GRID_DOTTED) begin
      step = (step * 3) / 2;
    end
    return (step == 0) ? 1 : step;
  endfunction

  function automatic longint unsigned snap_to_grid(input longint unsigned tick);
    longint unsigned g;
    longint unsigned sw;
    longint unsigned st;
    longint unsigned idx;
    longint unsigned target;
    longint unsigned mix;
    g = grid_ticks();
    sw = (settings.swing > Q8_ONE) ? Q8_ONE : settings.swing;
    st = (settings.strength > Q8_ONE) ? Q8_ONE : settings.strength;
    // nearest grid line, halfway rounds up
    idx = (2 * tick + g) / (2 * g);
    target = idx * g;
    // swing pushes odd grid lines late by round(swing * grid / 3)
    if (sw != 0 && (idx & 1) != 0) target += (2 * sw * g + 768) / 1536;
    mix = ((Q8_ONE - st) * tick + st * target + Q8_HALF) >> Q8_FRAC;
    return (mix > TICK_LIMIT) ? TICK_LIMIT : mix;
  endfunction

  function automatic quantized_note_t quantize_note(input logic [TICK_W-1:0] start_t,
                                                    input logic [TICK_W-1:0] end_t);
    quantized_note_t r;
    longint unsigned s0;
    longint unsigned e0;
    longint unsigned ns;
    longint          ne;
    s0 = start_t;
    e0 = end_t;
    ns = settings.snap_start ? snap_to_grid(s0) : s0;
    if (settings.snap_end) begin
      ne = longint'(snap_to_grid(e0));
    end else begin
      // keep the original length, which may be negative
      ne = longint'(ns) + (longint'(e0) - longint'(s0));
    end
    if (ne <= longint'(ns)) ne = longint'(ns) + 1;
    r.note_start = start_t;
    r.note_end = end_t;
    r.new_start = ns[TICK_W-1:0];
    r.new_end = (ne > longint'(TICK_LIMIT)) ? '1 : ne[TICK_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_error(input string msg);
    error_count++;
    // keep the log short when everything is off
    if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (quantized_q.size() == 0) begin
        flag_error($sformatf("unexpected item %h/%h", result_if.new_start, result_if.new_end));
      end else begin
        want = quantized_q.pop_front();
        if (result_if.new_start !== want.new_start)
          flag_error($sformatf("new_start %h, want %h (note %h..%h)", result_if.new_start,
                               want.new_start, want.note_start, want.note_end));
        if (result_if.new_end !== want.new_end)
          flag_error($sformatf("new_end %h, want %h (note %h..%h)", result_if.new_end,
                               want.new_end, want.note_start, want.note_end));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (note_if.valid && note_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_note_timing_quantizer: errors");
        $finish;
      end
    end
  end

  // result side: random pause after each item, plus a long hold-off on request
  initial begin : result_sink
    int unsigned pause;
    logic        taken;
    pause = 0;
    taken = 1'b0;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (taken) pause = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (choke_left > 0) begin
        choke_left--;
        result_if.ready <= 1'b0;
      end else if (pause > 0) begin
        pause--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      taken = result_if.valid && result_if.ready;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Entered and left at a falling edge.
  task automatic send_note(input logic [TICK_W-1:0] start_t, input logic [TICK_W-1:0] end_t);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      note_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    note_if.valid <= 1'b1;
    note_if.start_tick <= start_t;
    note_if.end_tick <= end_t;
    @(posedge clk_i);
    while (!note_if.ready) @(posedge clk_i);
    quantized_q.push_back(quantize_note(start_t, end_t));
    @(negedge clk_i);
  endtask

  task automatic send_random_note();
    longint unsigned g;
    longint unsigned s;
    longint unsigned e;
    g = grid_ticks();
    case ($urandom_range(0, 7))
      0: begin
        s = $urandom;
        e = $urandom;
      end
      1: begin
        // close to the top, where targets and ends saturate
        s = TICK_LIMIT - $urandom_range(0, 3 * g);
        e = s + $urandom_range(0, 4 * g);
      end
      2: begin
        s = $urandom;
        e = s - $urandom_range(0, 2 * g);
      end
      3, 4: begin
        // around the halfway point between two grid lines
        s = $urandom_range(0, 4096) * g + g / 2 + $urandom_range(0, 2) - 1;
        e = s + ($urandom_range(0, 1) ? g / 2 : $urandom_range(0, 3 * g));
      end
      default: begin
        s = $urandom;
        e = s + $urandom_range(1, 8 * g);
      end
    endcase
    send_note(s[TICK_W-1:0], e[TICK_W-1:0]);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_W'(value);
    @(negedge clk_i);
  endtask

  // Waits for the pipeline to drain, then rewrites every register.
  task automatic program_grid(input int unsigned ppq, input int unsigned note_value,
                              input int unsigned grid_mod, input int unsigned swing,
                              input int unsigned strength, input int unsigned snap_start,
                              input int unsigned snap_end);
    note_if.valid <= 1'b0;
    while (quantized_q.size() != 0) @(negedge clk_i);
    write_reg(REG_PPQ, ppq);
    write_reg(REG_NOTE, note_value);
    write_reg(REG_MOD, grid_mod);
    write_reg(REG_SWING, swing);
    write_reg(REG_STRENGTH, strength);
    write_reg(REG_SNAP_START, snap_start);
    write_reg(REG_SNAP_END, snap_end);
    cfg_we_i <= 1'b0;
    settings.ppq = ppq[PPQ_W-1:0];
    settings.note_value = note_value[NOTE_W-1:0];
    settings.grid_mod = grid_mod[MOD_W-1:0];
    settings.swing = swing[Q8_W-1:0];
    settings.strength = strength[Q8_W-1:0];
    settings.snap_start = snap_start[0];
    settings.snap_end = snap_end[0];
  endtask

  function automatic int unsigned pick_q8();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return Q8_ONE;
      2:       return $urandom_range(Q8_ONE + 1, (1 << Q8_W) - 1);
      default: return $urandom_range(1, Q8_ONE - 1);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_note(32'd0, 32'd0);
    send_note(32'd60, 32'd200);
    send_note(32'd59, 32'd59);
    send_note(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_note(32'hFFFF_FFF0, 32'd10);
  endtask

  task automatic test_zero_ppq_and_saturation();
    // zero ppq and a triplet both clamp the step to one tick
    program_grid(0, NOTE_QUARTER, GRID_TRIPLET, 511, 511, 1, 1);
    send_note(32'd5, 32'd3);
    send_note(32'hFFFF_FFFF, 32'd0);
    send_note(32'd7, 32'd7);
    // swing and strength above one get clipped
    program_grid(3, NOTE_WHOLE, GRID_DOTTED, 300, 400, 1, 1);
    send_note(32'd9, 32'd40);
    send_note(32'd27, 32'd30);
  endtask

  task automatic test_widest_grid();
    program_grid(65535, NOTE_WHOLE, GRID_DOTTED, 256, 256, 1, 1);
    // target lands past the top: start and end both pinned at max
    send_note(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_note(32'd196605, 32'd589815);
    program_grid(65535, NOTE_HALF, GRID_STRAIGHT, 128, 128, 1, 0);
    send_note(32'd100000, 32'd50000);
    send_note(32'hFFFF_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_reserved_modifier();
    program_grid(1000, NOTE_128TH, GRID_RESERVED, 100, 200, 0, 1);
    send_note(32'd12345, 32'd100);
    send_note(32'd7, 32'd40000);
    send_note(32'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_settings();
    int unsigned ppq;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 0) begin
        program_grid(65535, NOTE_WHOLE, GRID_DOTTED, Q8_ONE, Q8_ONE, 1, 1);
      end else if (phase == 1) begin
        program_grid(1, NOTE_128TH, GRID_TRIPLET, 0, 0, 0, 0);
      end else begin
        case ($urandom_range(0, 3))
          0:       ppq = $urandom_range(1, 65535);
          1:       ppq = $urandom_range(1, 2000);
          2:       ppq = ($urandom_range(0, 1) ? 65535 : $urandom_range(0, 1));
          default: ppq = $urandom_range(24, 960);
        endcase
        program_grid(ppq, $urandom_range(0, 7), $urandom_range(0, 3), pick_q8(), pick_q8(),
                     $urandom_range(0, 1), $urandom_range(0, 1));
      end
      gaps_on = (phase % 3 != 2);
      stalls_on = (phase % 4 != 3);
      repeat (90) send_random_note();
    end
  endtask

  task automatic test_output_backpressure();
    program_grid(480, NOTE_EIGHTH, GRID_STRAIGHT, 64, 192, 1, 1);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    // result side goes quiet long enough for the pipeline to fill and stall note_i
    choke_left = CHOKE_CYCLES;
    repeat (80) send_random_note();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PPQ;
    cfg_wdata_i = '0;
    note_if.valid = 1'b0;
    note_if.start_tick = '0;
    note_if.end_tick = '0;
    settings.ppq = 16'd480;
    settings.note_value = NOTE_W'(NOTE_16TH);
    settings.grid_mod = GRID_STRAIGHT;
    settings.swing = '0;
    settings.strength = Q8_ONE;
    settings.snap_start = 1'b1;
    settings.snap_end = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_zero_ppq_and_saturation();
    test_widest_grid();
    test_reserved_modifier();
    test_random_settings();
    test_output_backpressure();

    note_if.valid <= 1'b0;
    while (quantized_q.size() != 0) @(negedge clk_i);
    repeat (2 * RESULT_LATENCY) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb_note_timing_quantizer: clean");
    end else begin
      $display("tb_note_timing_quantizer: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ntq_pkg.sv
sv/ntq_if.sv
sv/ntq_grid.sv
sv/ntq_lane.sv
sv/ntq_merge.sv
sv/note_timing_quantizer.sv
sim/tb_note_timing_quantizer.sv
